// ===== design/rmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, stage counts and stage record types for the DCM-to-quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;                 // matrix element width
  localparam int RAD_W     = IN_W + 3;           // raw radicand, signed
  localparam int MAG_W     = IN_W + 1;           // |v_i|
  localparam int SQ1_W     = 2 * MAG_W;          // one square
  localparam int ROOT_W    = MAG_W + 1;          // floor(sqrt(sum of squares))
  localparam int SUM_W     = 2 * ROOT_W;         // sum of four squares
  localparam int REM_W     = ROOT_W + 2;         // sqrt remainder
  localparam int Q_W       = FRAC_BITS + 1;      // quotient, holds 1.0
  localparam int NUM_W     = MAG_W + Q_W;        // rounded dividend
  localparam int DREM_W    = ROOT_W + 1;         // divider remainder
  localparam int OUT_W     = 18;
  localparam int FRONT_N   = 4;                  // stages ahead of the sqrt
  localparam int PIPE_N    = FRONT_N + (ROOT_W + 1) + (Q_W + 1);

  localparam logic [RAD_W-1:0] ONE_RAD = RAD_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0]   ONE_Q   = Q_W'(1) << FRAC_BITS;

  // signed vector held as sign and magnitude, plus pivot
  typedef struct packed {
    logic [1:0]            piv;
    logic [3:0]            neg;
    logic [3:0][MAG_W-1:0] mag;
  } ent_t;

  typedef struct packed {
    logic [SUM_W-1:0]  x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [Q_W-1:0]    low;
    logic [Q_W-1:0]    q;
  } div_t;

endpackage
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q1.16 direction cosine matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with nine 18-bit signed elements
//   elem_00..elem_22. A beat is taken when in_valid is high and in_stall low.
//   Output channel: out_valid / out_stall with quat_scalar, quat_x, quat_y,
//   quat_z (Q1.16 signed) and pivot_index.
//   From input beat to output beat: 4 front stages
//   (radicands, pivot select, squares, two adds), 21 for the one-bit-per-
//   stage square root, 18 for the four-lane one-bit-per-stage divider, and
//   the output register. Throughput is one matrix per cycle while the receiver does not stall.
//   Reset clears all valid bits; payload registers are not reset.
//   When the receiver stalls a valid output, the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is dropped or repeated.
//   No state is kept between matrices.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [IN_W-1:0]  elem_00,
  input  wire logic signed [IN_W-1:0]  elem_01,
  input  wire logic signed [IN_W-1:0]  elem_02,
  input  wire logic signed [IN_W-1:0]  elem_10,
  input  wire logic signed [IN_W-1:0]  elem_11,
  input  wire logic signed [IN_W-1:0]  elem_12,
  input  wire logic signed [IN_W-1:0]  elem_20,
  input  wire logic signed [IN_W-1:0]  elem_21,
  input  wire logic signed [IN_W-1:0]  elem_22,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      quat_scalar,
  output logic signed [OUT_W-1:0]      quat_x,
  output logic signed [OUT_W-1:0]      quat_y,
  output logic signed [OUT_W-1:0]      quat_z,
  output logic [1:0]                   pivot_index
);

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sqrt_t            r;
    t       = {s.rem, s.x[SUM_W-1 -: 2]};
    trial   = (REM_W+2)'({s.root, 2'b01});
    r.x     = s.x << 2;
    if (t >= trial) begin
      r.rem  = REM_W'(t - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(t);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_t div_step(input div_t d, input logic [ROOT_W-1:0] n);
    logic [DREM_W-1:0] t;
    logic              ge;
    div_t              r;
    t     = {d.rem[DREM_W-2:0], d.low[Q_W-1]};
    ge    = (t >= DREM_W'(n));
    r.rem = ge ? DREM_W'(t - DREM_W'(n)) : t;
    r.low = d.low << 1;
    r.q   = {d.q[Q_W-2:0], ge};
    return r;
  endfunction

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic [PIPE_N-1:0] vld;

  // ---- stage 1: radicands and off-diagonal terms
  logic [RAD_W-1:0]      r_raw [4];
  logic [3:0][MAG_W-1:0] rad_c;
  logic [MAG_W-1:0]      pr    [6];
  logic [5:0]            p_neg;
  logic [5:0][MAG_W-1:0] p_mag;
  logic [RAD_W-1:0]      x00, x11, x22;

  always_comb begin
    x00 = RAD_W'(elem_00);
    x11 = RAD_W'(elem_11);
    x22 = RAD_W'(elem_22);
    r_raw[0] = ONE_RAD + x00 + x11 + x22;
    r_raw[1] = ONE_RAD + x00 - x11 - x22;
    r_raw[2] = ONE_RAD - x00 + x11 - x22;
    r_raw[3] = ONE_RAD - x00 - x11 + x22;
    for (int k = 0; k < 4; k++) begin
      rad_c[k] = r_raw[k][RAD_W-1] ? '0 : r_raw[k][MAG_W-1:0];
    end
    pr[0] = MAG_W'(elem_12) - MAG_W'(elem_21);
    pr[1] = MAG_W'(elem_20) - MAG_W'(elem_02);
    pr[2] = MAG_W'(elem_01) - MAG_W'(elem_10);
    pr[3] = MAG_W'(elem_01) + MAG_W'(elem_10);
    pr[4] = MAG_W'(elem_20) + MAG_W'(elem_02);
    pr[5] = MAG_W'(elem_12) + MAG_W'(elem_21);
    for (int k = 0; k < 6; k++) begin
      p_neg[k] = pr[k][MAG_W-1];
      p_mag[k] = p_neg[k] ? MAG_W'(-pr[k]) : pr[k];
    end
  end

  logic [3:0][MAG_W-1:0] s1_r;
  logic [5:0]            s1_pn;
  logic [5:0][MAG_W-1:0] s1_pm;

  // ---- stage 2: pivot select, vector assembly
  logic [1:0]       pa, pb, piv_sel;
  logic [MAG_W-1:0] ra, rb;
  ent_t             ent_next;

  always_comb begin
    pa = (s1_r[1] > s1_r[0]) ? 2'd1 : 2'd0;
    ra = (s1_r[1] > s1_r[0]) ? s1_r[1] : s1_r[0];
    pb = (s1_r[3] > s1_r[2]) ? 2'd3 : 2'd2;
    rb = (s1_r[3] > s1_r[2]) ? s1_r[3] : s1_r[2];
    piv_sel = (rb > ra) ? pb : pa;
    ent_next.piv = piv_sel;
    case (piv_sel)
      2'd0: begin
        ent_next.neg = {s1_pn[2], s1_pn[1], s1_pn[0], 1'b0};
        ent_next.mag = {s1_pm[2], s1_pm[1], s1_pm[0], s1_r[0]};
      end
      2'd1: begin
        ent_next.neg = {s1_pn[4], s1_pn[3], 1'b0, s1_pn[0]};
        ent_next.mag = {s1_pm[4], s1_pm[3], s1_r[1], s1_pm[0]};
      end
      2'd2: begin
        ent_next.neg = {s1_pn[5], 1'b0, s1_pn[3], s1_pn[1]};
        ent_next.mag = {s1_pm[5], s1_r[2], s1_pm[3], s1_pm[1]};
      end
      default: begin
        ent_next.neg = {1'b0, s1_pn[5], s1_pn[4], s1_pn[2]};
        ent_next.mag = {s1_r[3], s1_pm[5], s1_pm[4], s1_pm[2]};
      end
    endcase
  end

  ent_t                  s2_ent, s3_ent, s4_ent;
  logic [3:0][SQ1_W-1:0] s3_sq;
  logic [SQ1_W:0]        s4_sum [2];

  // ---- square root and divider pipelines
  sqrt_t             sq     [ROOT_W+1];
  ent_t              sq_ent [ROOT_W+1];
  div_t              dv     [Q_W+1][4];
  logic [ROOT_W-1:0] dv_n   [Q_W+1];
  ent_t              dv_ent [Q_W+1];

  logic [ROOT_W-1:0] norm;
  logic [NUM_W-1:0]  num [4];
  div_t              dv0_next [4];

  always_comb begin
    norm = sq[ROOT_W].root;
    for (int k = 0; k < 4; k++) begin
      num[k] = NUM_W'({sq_ent[ROOT_W].mag[k], FRAC_BITS'(0)}) + NUM_W'(norm >> 1);
      dv0_next[k].rem = DREM_W'(num[k][NUM_W-1:Q_W]);
      dv0_next[k].low = num[k][Q_W-1:0];
      dv0_next[k].q   = '0;
    end
  end

  // ---- output shaping
  logic [Q_W-1:0]   qc    [4];
  logic [OUT_W-1:0] q_out [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qc[k]    = (dv[Q_W][k].q > ONE_Q) ? ONE_Q : dv[Q_W][k].q;
      q_out[k] = dv_ent[Q_W].neg[k] ? OUT_W'(-OUT_W'(qc[k])) : OUT_W'(qc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[PIPE_N-2:0], in_valid};
      out_valid <= vld[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= rad_c;
      s1_pn  <= p_neg;
      s1_pm  <= p_mag;
      s2_ent <= ent_next;
      for (int k = 0; k < 4; k++) begin
        s3_sq[k] <= SQ1_W'(s2_ent.mag[k]) * SQ1_W'(s2_ent.mag[k]);
      end
      s3_ent    <= s2_ent;
      s4_sum[0] <= (SQ1_W+1)'(s3_sq[0]) + (SQ1_W+1)'(s3_sq[1]);
      s4_sum[1] <= (SQ1_W+1)'(s3_sq[2]) + (SQ1_W+1)'(s3_sq[3]);
      s4_ent    <= s3_ent;
      sq[0].x    <= SUM_W'(s4_sum[0]) + SUM_W'(s4_sum[1]);
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq_ent[0]  <= s4_ent;
      for (int i = 1; i <= ROOT_W; i++) begin
        sq[i]     <= sqrt_step(sq[i-1]);
        sq_ent[i] <= sq_ent[i-1];
      end
      for (int k = 0; k < 4; k++) begin
        dv[0][k] <= dv0_next[k];
      end
      dv_n[0]   <= norm;
      dv_ent[0] <= sq_ent[ROOT_W];
      for (int i = 1; i <= Q_W; i++) begin
        for (int k = 0; k < 4; k++) begin
          dv[i][k] <= div_step(dv[i-1][k], dv_n[i-1]);
        end
        dv_n[i]   <= dv_n[i-1];
        dv_ent[i] <= dv_ent[i-1];
      end
      quat_scalar <= q_out[0];
      quat_x      <= q_out[1];
      quat_y      <= q_out[2];
      quat_z      <= q_out[3];
      pivot_index <= dv_ent[Q_W].piv;
    end
  end

endmodule
`default_nettype wire

// ===== tb/rotation_matrix_to_quaternion_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives rotation matrices through the converter and checks every quaternion
// beat, field by field, against a behavioral Shepperd predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int LATENCY  = 44;
  localparam int WDOG_MAX = 5000;
  localparam int N_RAND   = 1156;
  localparam int N_DIR    = 14;
  localparam logic signed [IN_W-1:0] P1 = 18'sd65536;
  localparam logic signed [IN_W-1:0] M1 = -18'sd65536;
  localparam logic signed [IN_W-1:0] Z0 = 18'sd0;

  typedef logic signed [IN_W-1:0] elem_t;
  typedef struct packed {
    logic signed [OUT_W-1:0] qs, qx, qy, qz;
    logic [1:0]              piv;
  } quat_t;
  typedef struct {
    elem_t e [9];
    bit    has_exp;
    quat_t q;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  elem_t e00 = 0, e01 = 0, e02 = 0, e10 = 0, e11 = 0, e12 = 0, e20 = 0, e21 = 0,
    e22 = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [OUT_W-1:0] quat_scalar, quat_x, quat_y, quat_z;
  logic [1:0] pivot_index;

  quat_t quat_queue[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    drive_done = 0;
  bit    hold_rx = 0;       // long receiver hold-off request
  bit    hold_rx_ack = 0;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .elem_00(e00), .elem_01(e01), .elem_02(e02),
    .elem_10(e10), .elem_11(e11), .elem_12(e12),
    .elem_20(e20), .elem_21(e21), .elem_22(e22),
    .out_valid(out_valid), .out_stall(out_stall),
    .quat_scalar(quat_scalar), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .pivot_index(pivot_index)
  );

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, lo, hi, mid;
    lo = 0;
    hi = 64'd4294967295;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] unit_part(longint v, longint unsigned n);
    longint unsigned mag, q;
    longint s;
    mag = v < 0 ? -v : v;
    q = ((mag << FRAC_BITS) + (n >> 1)) / n;
    if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
    s = v < 0 ? -longint'(q) : longint'(q);
    return s[OUT_W-1:0];
  endfunction

  function automatic quat_t shepperd_quat(elem_t e [9]);
    longint m [9];
    longint r [4], v [4];
    longint unsigned ssq, n;
    int p;
    quat_t q;
    for (int i = 0; i < 9; i++) m[i] = e[i];
    r[0] = (1 << FRAC_BITS) + m[0] + m[4] + m[8];
    r[1] = (1 << FRAC_BITS) + m[0] - m[4] - m[8];
    r[2] = (1 << FRAC_BITS) - m[0] + m[4] - m[8];
    r[3] = (1 << FRAC_BITS) - m[0] - m[4] + m[8];
    p = 0;
    for (int k = 0; k < 4; k++) if (r[k] < 0) r[k] = 0;
    for (int k = 1; k < 4; k++) if (r[k] > r[p]) p = k;
    case (p)
      0: begin
        v[0] = r[0]; v[1] = m[5] - m[7]; v[2] = m[6] - m[2]; v[3] = m[1] - m[3];
      end
      1: begin
        v[1] = r[1]; v[2] = m[1] + m[3]; v[3] = m[6] + m[2]; v[0] = m[5] - m[7];
      end
      2: begin
        v[2] = r[2]; v[1] = m[1] + m[3]; v[3] = m[5] + m[7]; v[0] = m[6] - m[2];
      end
      default: begin
        v[3] = r[3]; v[1] = m[6] + m[2]; v[2] = m[5] + m[7]; v[0] = m[1] - m[3];
      end
    endcase
    ssq = 0;
    for (int k = 0; k < 4; k++) ssq += longint'(v[k] * v[k]);
    n = int_sqrt(ssq);
    if (n == 0) n = 1;
    q.qs = unit_part(v[0], n);
    q.qx = unit_part(v[1], n);
    q.qy = unit_part(v[2], n);
    q.qz = unit_part(v[3], n);
    q.piv = p[1:0];
    return q;
  endfunction

  function automatic elem_t rand_elem();
    int s;
    s = $urandom_range(0, 9);
    if (s == 0) return elem_t'($urandom);          // full 18-bit range, any bit
    if (s == 1) return ($urandom_range(0, 1)) ? P1 : M1;
    return elem_t'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  // random rotation-ish matrix: diagonal dominant in one slot picks the pivot, except in the all-random mode
  function automatic void rand_matrix(output elem_t e [9]);
    int mode;
    mode = $urandom_range(0, 4);
    for (int i = 0; i < 9; i++) e[i] = rand_elem();
    if (mode < 4) begin
      for (int i = 0; i < 9; i++) e[i] = elem_t'(int'(e[i]) / 4);
      case (mode)
        0: begin
          e[0] = elem_t'(P1 - 300); e[4] = elem_t'(P1 - 500); e[8] = elem_t'(P1 - 200);
        end
        1: begin
          e[0] = elem_t'(P1 - 100); e[4] = elem_t'(M1 + 700); e[8] = elem_t'(M1 + 900);
        end
        2: begin
          e[0] = elem_t'(M1 + 400); e[4] = elem_t'(P1 - 50); e[8] = elem_t'(M1 + 30);
        end
        default: begin
          e[0] = elem_t'(M1 + 20); e[4] = elem_t'(M1 + 600); e[8] = elem_t'(P1 - 10);
        end
      endcase
    end
  endfunction

  task automatic send_matrix(elem_t e [9]);
    e00 <= e[0]; e01 <= e[1]; e02 <= e[2];
    e10 <= e[3]; e11 <= e[4]; e12 <= e[5];
    e20 <= e[6]; e21 <= e[7]; e22 <= e[8];
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_queue.push_back(shepperd_quat(e));
  endtask

  task automatic gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  dir_row_t dir_rows [N_DIR];

  function automatic dir_row_t mk(elem_t a, elem_t b, elem_t c, elem_t d, elem_t f,
                                  elem_t g, elem_t h, elem_t i, elem_t j);
    dir_row_t r;
    r.e[0] = a; r.e[1] = b; r.e[2] = c; r.e[3] = d; r.e[4] = f;
    r.e[5] = g; r.e[6] = h; r.e[7] = i; r.e[8] = j;
    r.has_exp = 0;
    return r;
  endfunction

  function automatic quat_t qv(int s, int x, int y, int z, int p);
    quat_t q;
    q.qs = OUT_W'(s); q.qx = OUT_W'(x); q.qy = OUT_W'(y); q.qz = OUT_W'(z);
    q.piv = 2'(p);
    return q;
  endfunction

  initial begin
    elem_t e [9];
    quat_t pq;
    // identity and the three half-turns: exact unit results
    dir_rows[0] = mk(P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1);
    dir_rows[0].has_exp = 1; dir_rows[0].q = qv(65536, 0, 0, 0, 0);
    dir_rows[1] = mk(P1, Z0, Z0, Z0, M1, Z0, Z0, Z0, M1);
    dir_rows[1].has_exp = 1; dir_rows[1].q = qv(0, 65536, 0, 0, 1);
    dir_rows[2] = mk(M1, Z0, Z0, Z0, P1, Z0, Z0, Z0, M1);
    dir_rows[2].has_exp = 1; dir_rows[2].q = qv(0, 0, 65536, 0, 2);
    dir_rows[3] = mk(M1, Z0, Z0, Z0, M1, Z0, Z0, Z0, P1);
    dir_rows[3].has_exp = 1; dir_rows[3].q = qv(0, 0, 0, 65536, 3);
    // all-zero: four equal radicands, tie goes to the scalar
    dir_rows[4] = mk(Z0, Z0, Z0, Z0, Z0, Z0, Z0, Z0, Z0);
    dir_rows[4].has_exp = 1; dir_rows[4].q = qv(65536, 0, 0, 0, 0);
    // 90 degree turns about each axis
    dir_rows[5] = mk(P1, Z0, Z0, Z0, Z0, M1, Z0, P1, Z0);
    dir_rows[6] = mk(Z0, Z0, P1, Z0, P1, Z0, M1, Z0, Z0);
    dir_rows[7] = mk(Z0, M1, Z0, P1, Z0, Z0, Z0, Z0, P1);
    // every element at an extreme, all negative and all positive
    dir_rows[8] = mk(M1, M1, M1, M1, M1, M1, M1, M1, M1);
    dir_rows[9] = mk(P1, P1, P1, P1, P1, P1, P1, P1, P1);
    // out-of-range codes: most negative and most positive 18-bit values
    dir_rows[10] = mk(-18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071,
                      -18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071, 18'sd131071);
    dir_rows[11] = mk(18'sd131071, -18'sd131072, 18'sd131071, -18'sd131072,
                      18'sd131071, -18'sd131072, 18'sd131071, -18'sd131072, -18'sd131072);
    // negative radicands clamped, rounding overshoot
    dir_rows[12] = mk(M1, 18'sd1, -18'sd1, 18'sd3, M1, 18'sd5, -18'sd7, 18'sd9, M1);
    dir_rows[13] = mk(18'sd1, 18'sd40000, Z0, -18'sd40000, 18'sd1, Z0, Z0, Z0, 18'sd1);

    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].has_exp) begin
        pq = shepperd_quat(dir_rows[i].e);
        if (pq != dir_rows[i].q) begin
          $display("%0t row %0d exp %0d %0d %0d %0d piv %0d got %0d %0d %0d %0d piv %0d",
                   $time, i, dir_rows[i].q.qs, dir_rows[i].q.qx, dir_rows[i].q.qy,
                   dir_rows[i].q.qz, dir_rows[i].q.piv, pq.qs, pq.qx, pq.qy, pq.qz,
                   pq.piv);
          errors++;
        end
      end
      send_matrix(dir_rows[i].e);
      if (dir_rows[i].has_exp) quat_queue[$] = dir_rows[i].q;
      gap();
    end

    for (int n = 0; n < N_RAND; n++) begin
      if (n == 300) begin
        // receiver holds off while we keep offering back-to-back
        in_valid <= 0;
        hold_rx <= 1;
        wait (hold_rx_ack);
        for (int k = 0; k < 80; k++) begin
          rand_matrix(e);
          send_matrix(e);
        end
        hold_rx <= 0;
      end
      if (n == 700) begin
        in_valid <= 0;
        wait (quat_queue.size() == 0);
        @(posedge clk);
      end
      rand_matrix(e);
      send_matrix(e);
      if (n % 200 < 100) gap();
    end
    in_valid <= 0;
    drive_done <= 1;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int w;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1;
        hold_rx_ack <= 1;
        repeat (150) @(posedge clk);
        out_stall <= 0;
        wait (!hold_rx);
      end else begin
        w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
        if (w > 0 && $urandom_range(0, 3) == 0) begin
          out_stall <= 1;
          repeat (w) @(posedge clk);
        end
        out_stall <= 0;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $display("%0t unexpected beat: %0d %0d %0d %0d piv %0d", $time,
                 quat_scalar, quat_x, quat_y, quat_z, pivot_index);
        errors++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (quat_scalar !== exp_q.qs) begin
          $display("%0t quat_scalar exp %0d got %0d", $time, exp_q.qs, quat_scalar);
          errors++;
        end
        if (quat_x !== exp_q.qx) begin
          $display("%0t quat_x exp %0d got %0d", $time, exp_q.qx, quat_x);
          errors++;
        end
        if (quat_y !== exp_q.qy) begin
          $display("%0t quat_y exp %0d got %0d", $time, exp_q.qy, quat_y);
          errors++;
        end
        if (quat_z !== exp_q.qz) begin
          $display("%0t quat_z exp %0d got %0d", $time, exp_q.qz, quat_z);
          errors++;
        end
        if (pivot_index !== exp_q.piv) begin
          $display("%0t pivot_index exp %0d got %0d", $time, exp_q.piv, pivot_index);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("== FAIL ==");
        $finish;
      end
      if (drive_done && quat_queue.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && quat_queue.size() == 0) begin
          $display("== PASS ==");
        end else begin
          $display("== FAIL ==");
        end
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
design/rmq_pkg.sv
design/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_tb.sv
